@@ src/nfrag_pkg.sv @@
package nfrag_pkg;

    localparam int CNT_W = 16;
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int MP_W = 10;
    localparam logic [MP_W-1:0] HDR_LEN = 10'd3;
    localparam logic [MP_W-1:0] MAX_PAYLOAD_RESET = 10'd23;
    localparam int FLAG_START_BIT = 0;
    localparam int FLAG_END_BIT = 1;

    typedef enum logic [1:0] {
        K_ERR   = 2'd0,
        K_EMPTY = 2'd1,
        K_FULL  = 2'd2,
        K_BODY  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] flags;
        logic [7:0] txn;
        logic [7:0] seq;
        logic [7:0] data;
        logic       pkt_last;
        logic       warn_active;
        logic       warn_inactive;
    } t_cmd;

endpackage

@@ src/nfrag_front.sv @@
module nfrag_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [nfrag_pkg::MP_W-1:0]          i_max_payload,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic [15:0]                         i_call_total,
    input  logic                                i_txn_start,
    input  logic                                i_txn_end,
    input  logic                                i_q_full,
    output logic                                o_push,
    output nfrag_pkg::t_cmd                     o_cmd
);

    logic [7:0]                    r_txn, n_txn;
    logic [7:0]                    r_seq, n_seq;
    logic                          r_inflight, n_inflight;
    logic [nfrag_pkg::CNT_W-1:0]   r_sent, n_sent;
    logic [nfrag_pkg::MP_W-1:0]    r_fill, n_fill;

    logic [nfrag_pkg::CNT_W-1:0]   total, bs, sent, remain;
    logic [nfrag_pkg::MP_W-1:0]    cap, pf;
    logic [nfrag_pkg::MP_W:0]      fill;
    logic [7:0]                    txn_n, seq_n;
    logic                          inf_n, wa, wc, first, last_pkt, call_done, pkt_done;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        total  = i_call_total[nfrag_pkg::CNT_W-1:0];
        cap    = i_max_payload - nfrag_pkg::HDR_LEN;
        bs     = (total == '0) ? '0 : r_sent;
        pf     = (total == '0) ? '0 : r_fill;
        first  = (bs == '0);
        txn_n  = r_txn;
        seq_n  = r_seq;
        inf_n  = r_inflight;
        wa     = 1'b0;
        wc     = 1'b0;
        if (first) begin
            if (i_txn_start) begin
                wa    = r_inflight;
                txn_n = r_txn + 8'd1;
                seq_n = 8'd0;
                inf_n = 1'b1;
            end else if (!r_inflight) begin
                wc = 1'b1;
            end
        end
        remain    = total - bs;
        last_pkt  = (bs >= total) || (remain <= nfrag_pkg::CNT_W'(cap));
        fill      = {1'b0, pf} + 11'd1;
        sent      = bs + 1'b1;
        call_done = (sent >= total) || (sent == '0);
        pkt_done  = call_done || (fill >= {1'b0, cap});

        o_cmd.kind          = nfrag_pkg::K_BODY;
        o_cmd.flags         = 2'b00;
        o_cmd.txn           = txn_n;
        o_cmd.seq           = seq_n;
        o_cmd.data          = i_data_byte;
        o_cmd.pkt_last      = pkt_done;
        o_cmd.warn_active   = wa;
        o_cmd.warn_inactive = wc;

        n_txn      = r_txn;
        n_seq      = r_seq;
        n_inflight = r_inflight;
        n_sent     = r_sent;
        n_fill     = r_fill;

        if (i_max_payload <= nfrag_pkg::HDR_LEN) begin
            o_cmd.kind          = nfrag_pkg::K_ERR;
            o_cmd.txn           = 8'd0;
            o_cmd.seq           = 8'd0;
            o_cmd.data          = 8'd0;
            o_cmd.pkt_last      = 1'b0;
            o_cmd.warn_active   = 1'b0;
            o_cmd.warn_inactive = 1'b0;
        end else if (total == '0) begin
            o_cmd.kind                            = nfrag_pkg::K_EMPTY;
            o_cmd.flags[nfrag_pkg::FLAG_START_BIT] = i_txn_start;
            o_cmd.flags[nfrag_pkg::FLAG_END_BIT]   = i_txn_end;
            o_cmd.pkt_last                        = 1'b1;
            n_txn      = txn_n;
            n_seq      = seq_n + 8'd1;
            n_inflight = i_txn_end ? 1'b0 : inf_n;
            n_sent     = '0;
            n_fill     = '0;
        end else begin
            o_cmd.kind = (pf == '0) ? nfrag_pkg::K_FULL : nfrag_pkg::K_BODY;
            o_cmd.flags[nfrag_pkg::FLAG_START_BIT] = i_txn_start && first;
            o_cmd.flags[nfrag_pkg::FLAG_END_BIT]   = i_txn_end && last_pkt;
            n_txn      = txn_n;
            n_seq      = pkt_done ? seq_n + 8'd1 : seq_n;
            n_fill     = pkt_done ? '0 : fill[nfrag_pkg::MP_W-1:0];
            n_inflight = (call_done && i_txn_end) ? 1'b0 : inf_n;
            n_sent     = call_done ? '0 : sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txn      <= '0;
            r_seq      <= '0;
            r_inflight <= 1'b0;
            r_sent     <= '0;
            r_fill     <= '0;
        end else if (o_push) begin
            r_txn      <= n_txn;
            r_seq      <= n_seq;
            r_inflight <= n_inflight;
            r_sent     <= n_sent;
            r_fill     <= n_fill;
        end
    end

endmodule

@@ src/nfrag_queue.sv @@
module nfrag_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nfrag_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output nfrag_pkg::t_cmd o_head,
    output logic            o_valid,
    output logic            o_full
);

    nfrag_pkg::t_cmd                r_mem [nfrag_pkg::QDEPTH];
    logic [nfrag_pkg::QIDX_W-1:0]   r_wr, r_rd;
    logic [nfrag_pkg::QIDX_W:0]     r_count;
    logic                           do_pop;

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (nfrag_pkg::QIDX_W + 1)'(nfrag_pkg::QDEPTH));
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/nfrag_back.sv @@
module nfrag_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nfrag_pkg::t_cmd i_cmd,
    input  logic            i_q_valid,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_is_header,
    output logic            o_packet_last,
    output logic            o_item_last,
    output logic            o_status,
    output logic            o_warn_active,
    output logic            o_warn_inactive
);

    logic [1:0] r_phase;
    logic       load, cmd_last;
    logic [7:0] b;
    logic       hdr, pl, il, st;

    assign load  = i_q_valid && (!o_valid || i_ready);
    assign o_pop = load && cmd_last;

    always_comb begin
        b   = i_cmd.data;
        hdr = 1'b0;
        pl  = 1'b0;
        il  = 1'b0;
        st  = 1'b0;
        cmd_last = 1'b0;
        case (i_cmd.kind)
            nfrag_pkg::K_ERR: begin
                b        = 8'd0;
                st       = 1'b1;
                il       = 1'b1;
                cmd_last = 1'b1;
            end
            nfrag_pkg::K_BODY: begin
                pl       = i_cmd.pkt_last;
                il       = 1'b1;
                cmd_last = 1'b1;
            end
            nfrag_pkg::K_EMPTY, nfrag_pkg::K_FULL: begin
                case (r_phase)
                    2'd0: begin
                        b   = {6'd0, i_cmd.flags};
                        hdr = 1'b1;
                    end
                    2'd1: begin
                        b   = i_cmd.txn;
                        hdr = 1'b1;
                    end
                    2'd2: begin
                        b   = i_cmd.seq;
                        hdr = 1'b1;
                        if (i_cmd.kind == nfrag_pkg::K_EMPTY) begin
                            pl       = 1'b1;
                            il       = 1'b1;
                            cmd_last = 1'b1;
                        end
                    end
                    default: begin
                        pl       = i_cmd.pkt_last;
                        il       = 1'b1;
                        cmd_last = 1'b1;
                    end
                endcase
            end
            default: begin
                cmd_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= cmd_last ? 2'd0 : r_phase + 2'd1;
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_byte          <= b;
            o_is_header     <= hdr;
            o_packet_last   <= pl;
            o_item_last     <= il;
            o_status        <= st;
            o_warn_active   <= i_cmd.warn_active;
            o_warn_inactive <= i_cmd.warn_inactive;
        end
    end

endmodule

@@ src/notification_fragmenter_unit.sv @@
// The first result of an item is registered in the command queue, then in the output register.
// The output register emits one byte per cycle while m_axis_tready is high; an item gives
// one body byte, three header bytes and a body byte when it opens a packet, three for an empty call.
// A four-entry command queue between the classifier and the emitter absorbs stalls.
// Reset is synchronous and active low; it clears the counters, the queue and the
// output valid, and loads the default payload size of 23 bytes.
module notification_fragmenter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nfrag_pkg::MP_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // data_byte, call_total
    input  logic [1:0]                    s_axis_tuser,  // txn_start, txn_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // out_byte
    output logic                          m_axis_tlast,
    output logic [4:0]                    m_axis_tuser   // is_header, item_last, status,
                                                         // start_while_active,
                                                         // continue_inactive
);

    logic [nfrag_pkg::MP_W-1:0] r_max_payload;
    nfrag_pkg::t_cmd            push_cmd, head_cmd;
    logic                       push, pop, q_valid, q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= nfrag_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    nfrag_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_payload (r_max_payload),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_call_total  (s_axis_tdata[23:8]),
        .i_txn_start   (s_axis_tuser[0]),
        .i_txn_end     (s_axis_tuser[1]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    nfrag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    nfrag_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_q_valid       (q_valid),
        .o_pop           (pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_byte          (m_axis_tdata),
        .o_is_header     (m_axis_tuser[0]),
        .o_packet_last   (m_axis_tlast),
        .o_item_last     (m_axis_tuser[1]),
        .o_status        (m_axis_tuser[2]),
        .o_warn_active   (m_axis_tuser[3]),
        .o_warn_inactive (m_axis_tuser[4])
    );

endmodule

@@ src/nfrag_checker.sv @@
module nfrag_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [4:0] m_axis_tuser
);

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[1] && !m_axis_tlast && !m_axis_tuser[0] && m_axis_tdata == 8'd0)
        else $error("Error result carries packet content.");

    a_body_item_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("Body byte is not the last result of its item.");

    a_hdr_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tlast == m_axis_tuser[1]))
        else $error("Header byte closes a packet and an item inconsistently.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled output transaction changed.");

endmodule

bind notification_fragmenter_unit nfrag_checker u_nfrag_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ test/notification_fragmenter_unit_tb.sv @@
`timescale 1ns / 1ps

module notification_fragmenter_unit_tb;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       packet_last;
        logic       item_last;
        logic       status;
        logic       warn_active;
        logic       warn_inactive;
    } t_frag_byte;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [nfrag_pkg::MP_W-1:0] i_cfg_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [23:0]                s_axis_tdata;
    logic [1:0]                 s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [7:0]                 m_axis_tdata;
    logic                       m_axis_tlast;
    logic [4:0]                 m_axis_tuser;

    t_frag_byte expected_bytes[$];
    int errors = 0;
    int items_offered = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_left = 0;

    logic [nfrag_pkg::MP_W-1:0]  payload_size = nfrag_pkg::MAX_PAYLOAD_RESET;
    logic [7:0]                  txn_id = '0;
    logic [7:0]                  seq_no = '0;
    logic                        in_flight = 1'b0;
    logic [nfrag_pkg::CNT_W-1:0] call_taken = '0;
    logic [nfrag_pkg::MP_W-1:0]  packet_fill = '0;

    notification_fragmenter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_frag_byte make_byte(logic [7:0] value, logic header, logic pkt_last,
                                             logic warn_active, logic warn_inactive);
        t_frag_byte b;
        b = '0;
        b.out_byte = value;
        b.is_header = header;
        b.packet_last = pkt_last;
        b.warn_active = warn_active;
        b.warn_inactive = warn_inactive;
        return b;
    endfunction

    function automatic void add_header(logic [1:0] flags, logic pkt_last,
                                       logic warn_active, logic warn_inactive);
        expected_bytes.push_back(make_byte({6'b0, flags}, 1'b1, 1'b0, warn_active, warn_inactive));
        expected_bytes.push_back(make_byte(txn_id, 1'b1, 1'b0, warn_active, warn_inactive));
        expected_bytes.push_back(make_byte(seq_no, 1'b1, pkt_last, warn_active, warn_inactive));
    endfunction

    function automatic void predict_fragments(logic [7:0] data,
                                              logic [nfrag_pkg::CNT_W-1:0] total,
                                              logic txn_start, logic txn_end);
        t_frag_byte err_byte;
        logic [nfrag_pkg::MP_W-1:0]  capacity;
        logic [nfrag_pkg::MP_W-1:0]  fill_next;
        logic [nfrag_pkg::CNT_W-1:0] taken_next;
        logic [1:0]       flags;
        logic             warn_active;
        logic             warn_inactive;
        logic             call_done;
        logic             packet_done;
        logic             closing_pkt;
        warn_active = 1'b0;
        warn_inactive = 1'b0;
        flags = '0;
        if (payload_size <= nfrag_pkg::HDR_LEN) begin
            err_byte = '0;
            err_byte.item_last = 1'b1;
            err_byte.status = 1'b1;
            expected_bytes.push_back(err_byte);
            return;
        end
        capacity = payload_size - nfrag_pkg::HDR_LEN;
        if (total == 0) begin
            call_taken = '0;
            packet_fill = '0;
        end
        if (call_taken == 0) begin
            if (txn_start) begin
                warn_active = in_flight;
                txn_id = txn_id + 8'd1;
                seq_no = '0;
                in_flight = 1'b1;
            end else if (!in_flight) begin
                warn_inactive = 1'b1;
            end
        end
        if (total == 0) begin
            flags[nfrag_pkg::FLAG_START_BIT] = txn_start;
            flags[nfrag_pkg::FLAG_END_BIT] = txn_end;
            add_header(flags, 1'b1, warn_active, warn_inactive);
            seq_no = seq_no + 8'd1;
            if (txn_end) begin
                in_flight = 1'b0;
            end
        end else begin
            if (packet_fill == 0) begin
                closing_pkt = (call_taken >= total) ||
                              (int'(total) - int'(call_taken) <= int'(capacity));
                flags[nfrag_pkg::FLAG_START_BIT] = txn_start && (call_taken == 0);
                flags[nfrag_pkg::FLAG_END_BIT] = txn_end && closing_pkt;
                add_header(flags, 1'b0, warn_active, warn_inactive);
            end
            fill_next = packet_fill + 1'b1;
            taken_next = call_taken + 1'b1;
            call_done = (taken_next >= total) || (taken_next == 0);
            packet_done = call_done || (fill_next >= capacity);
            expected_bytes.push_back(make_byte(data, 1'b0, packet_done,
                                               warn_active, warn_inactive));
            if (packet_done) begin
                seq_no = seq_no + 8'd1;
                packet_fill = '0;
            end else begin
                packet_fill = fill_next;
            end
            if (call_done) begin
                call_taken = '0;
                if (txn_end) begin
                    in_flight = 1'b0;
                end
            end else begin
                call_taken = taken_next;
            end
        end
        expected_bytes[expected_bytes.size() - 1].item_last = 1'b1;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_output
        t_frag_byte seen;
        t_frag_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
                    m_axis_tuser[2], m_axis_tuser[3], m_axis_tuser[4]};
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, seen);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                compare_field("out_byte", want.out_byte, seen.out_byte);
                compare_field("is_header", want.is_header, seen.is_header);
                compare_field("packet_last", want.packet_last, seen.packet_last);
                compare_field("item_last", want.item_last, seen.item_last);
                compare_field("status", want.status, seen.status);
                compare_field("start_while_active", want.warn_active, seen.warn_active);
                compare_field("continue_inactive", want.warn_inactive, seen.warn_inactive);
            end
        end
    end

    task automatic offer_item(input logic [7:0] data, input logic [nfrag_pkg::CNT_W-1:0] total,
                              input logic txn_start, input logic txn_end);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {total, data};
        s_axis_tuser <= {txn_end, txn_start};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_fragments(data, total, txn_start, txn_end);
        items_offered++;
    endtask

    task automatic offer_call(input logic [nfrag_pkg::CNT_W-1:0] total, input logic txn_start,
                              input logic txn_end, input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            offer_item(8'($urandom_range(255)), total, txn_start, txn_end);
        end
    endtask

    task automatic stop_offering();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_payload_size(input logic [nfrag_pkg::MP_W-1:0] value);
        stop_offering();
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        payload_size = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
    endtask

    task automatic test_basic_calls();
        offer_item(8'h00, 16'd0, 1'b0, 1'b0);
        offer_item(8'hFF, 16'd0, 1'b1, 1'b1);
        offer_item(8'h00, 16'd3, 1'b1, 1'b1);
        offer_item(8'hFF, 16'd3, 1'b1, 1'b1);
        offer_item(8'h5A, 16'd3, 1'b1, 1'b1);
        offer_call(16'd2, 1'b0, 1'b0, 2);
        offer_item(8'hA5, 16'd1, 1'b1, 1'b0);
        offer_item(8'h3C, 16'd1, 1'b1, 1'b1);
    endtask

    task automatic test_broken_calls();
        // A shrunken total ends the call on the current byte.
        offer_call(16'd5, 1'b1, 1'b0, 2);
        offer_item(8'h81, 16'd2, 1'b1, 1'b0);
        // An empty call abandons the open packet.
        offer_call(16'd4, 1'b0, 1'b1, 2);
        offer_item(8'h7E, 16'd0, 1'b0, 1'b1);
        offer_item(8'hFF, 16'hFFFF, 1'b1, 1'b0);
        offer_item(8'h00, 16'h8000, 1'b0, 1'b0);
        offer_item(8'h42, 16'd0, 1'b0, 1'b1);
    endtask

    task automatic test_payload_limits();
        write_payload_size(10'd4);
        offer_call(16'd3, 1'b1, 1'b1, 3);
        write_payload_size(10'd5);
        offer_call(16'd5, 1'b1, 1'b1, 5);
        write_payload_size(nfrag_pkg::MAX_PAYLOAD_RESET);
        offer_call(16'd12, 1'b1, 1'b0, 5);
        // Capacity drops below the fill of the open packet.
        write_payload_size(10'd6);
        offer_call(16'd12, 1'b1, 1'b0, 7);
        write_payload_size(10'd517);
        offer_call(16'd8, 1'b1, 1'b1, 8);
        write_payload_size(10'd3);
        offer_item(8'hFF, 16'hFFFF, 1'b1, 1'b1);
        offer_item(8'h00, 16'd0, 1'b0, 1'b0);
        write_payload_size(10'd0);
        offer_item(8'h96, 16'd7, 1'b1, 1'b0);
        write_payload_size(nfrag_pkg::MAX_PAYLOAD_RESET);
    endtask

    task automatic offer_random_call();
        int unsigned pick;
        logic [nfrag_pkg::CNT_W-1:0] total;
        logic txn_start;
        logic txn_end;
        int nbytes;
        pick = $urandom_range(99);
        txn_start = ($urandom_range(99) < 55);
        txn_end = 1'($urandom_range(1));
        if (pick < 10) begin
            total = '0;
        end else if (pick < 85) begin
            total = nfrag_pkg::CNT_W'($urandom_range(10, 1));
        end else begin
            total = nfrag_pkg::CNT_W'($urandom_range(48, 11));
        end
        nbytes = (total == 0) ? 1 : int'(total);
        for (int i = 0; i < nbytes; i++) begin
            pick = $urandom_range(99);
            if (i > 0 && pick < 4) begin
                offer_item(8'($urandom_range(255)), 16'd0, txn_start, txn_end);
                return;
            end
            if (i > 0 && pick < 8) begin
                offer_item(8'($urandom_range(255)), nfrag_pkg::CNT_W'($urandom_range(65535)),
                           txn_start, txn_end);
                return;
            end
            offer_item(8'($urandom_range(255)), total, txn_start, txn_end);
        end
    endtask

    task automatic test_random_traffic();
        int goal;
        set_idling(24, 69);
        write_payload_size(nfrag_pkg::MP_W'($urandom_range(26, 4)));
        goal = items_offered + 10;
        while (items_offered < goal) offer_random_call();
        set_idling(69, 24);
        write_payload_size(nfrag_pkg::MP_W'($urandom_range(10, 4)));
        goal = items_offered + 10;
        while (items_offered < goal) offer_random_call();
        set_idling(0, 0);
        write_payload_size(nfrag_pkg::MP_W'($urandom_range(40, 4)));
        goal = items_offered + 10;
        while (items_offered < goal) offer_random_call();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        write_payload_size(nfrag_pkg::MAX_PAYLOAD_RESET);
        @(posedge i_clk);
        hold_left = 120;
        offer_call(16'd20, 1'b1, 1'b1, 20);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(24, 69);
        test_basic_calls();
        test_broken_calls();
        test_payload_limits();
        test_random_traffic();
        test_backpressure();

        stop_offering();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
